>>> src/wsc_pkg.sv
// Shared widths, register indexes, fixed-point constants and saturation helper.
package wsc_pkg;

	localparam int STAMP_W   = 40;
	localparam int SPEED_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_BIAS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT_US     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_ENABLE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN    = 3'd7;

	// Q1.16 one, position-to-speed scale (us per s)
	localparam logic [16:0]        ONE_Q16   = 17'd65536;
	localparam logic signed [24:0] POS_SCALE = 25'sd1000000;

	// reset values
	localparam logic signed [23:0] RST_GAIN   = 24'sd65536;
	localparam logic [30:0]        RST_LIMIT  = 31'd65536;
	localparam logic [30:0]        RST_DZONE  = 31'd1311;
	localparam logic [23:0]        RST_GAP    = 24'd200000;

	// saturate a 64-bit signed value to 32 bits signed
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh000000007FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sh0000000080000000)
			r = -32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

>>> src/wsc_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
interface wsc_cfg_if import wsc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/wsc_in_if.sv
// Wheel sample channel: stamp, optional velocity, optional position.
interface wsc_in_if import wsc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STAMP_W-1:0]        stamp_us;
	logic                      velocity_present;
	logic signed [SPEED_W-1:0] velocity_value;
	logic                      position_present;
	logic signed [SPEED_W-1:0] position_value;

	modport source (output valid, output stamp_us, output velocity_present,
		output velocity_value, output position_present, output position_value,
		input ready);
	modport sink (input valid, input stamp_us, input velocity_present,
		input velocity_value, input position_present, input position_value,
		output ready);
endinterface

>>> src/wsc_out_if.sv
// Filtered speed channel: stamp and forward speed with valid/ready.
interface wsc_out_if import wsc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [STAMP_W-1:0]        out_stamp_us;
	logic signed [SPEED_W-1:0] forward_speed;

	modport source (output valid, output out_stamp_us, output forward_speed, input ready);
	modport sink (input valid, input out_stamp_us, input forward_speed, output ready);
endinterface

>>> src/wheel_speed_conditioner.sv
// Wheel speed conditioner: sequenced gain, dead zone, clamp and lowpass over one multiplier.
// Items are accepted only in idle, one at a time; a skipped item returns to idle. The velocity
// path runs gain, bias, dead zone and clamp, lowpass and output; the position fallback path first
// forms a speed in the bit-serial divider and applies position gain. The sequencer owns the single
// multiplier and divider, and holds in its last state while an earlier result still waits.
// Reset (arst_n low, asynchronous): registers to their defaults, filter state cleared.
module wheel_speed_conditioner import wsc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	wsc_cfg_if.sink    cfg,
	wsc_in_if.sink     sample,
	wsc_out_if.source  result
);

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_MULD  = 4'd2;   // position delta * 1e6
	localparam logic [3:0] ST_DIVI  = 4'd3;   // take magnitude, load divider
	localparam logic [3:0] ST_DIV   = 4'd4;   // one quotient bit per cycle
	localparam logic [3:0] ST_DIVF  = 4'd5;   // restore sign, saturate
	localparam logic [3:0] ST_MULP  = 4'd6;   // * position_gain
	localparam logic [3:0] ST_MULPF = 4'd7;
	localparam logic [3:0] ST_MULV  = 4'd8;   // * velocity_gain
	localparam logic [3:0] ST_BIAS  = 4'd9;
	localparam logic [3:0] ST_LIMIT = 4'd10;  // dead zone then clamp
	localparam logic [3:0] ST_MULW  = 4'd11;  // w * measured
	localparam logic [3:0] ST_MULS  = 4'd12;  // (1 - w) * smoothed
	localparam logic [3:0] ST_SUM   = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	localparam int         DVD_W     = 53;    // |33-bit delta * 1e6| fits 53 bits
	localparam logic [5:0] DIV_LAST  = 6'(DVD_W - 1);

	logic [3:0] state_q;

	// configuration registers
	logic signed [23:0] vgain_q;
	logic signed [31:0] vbias_q;
	logic [30:0]        limit_q;
	logic [30:0]        dzone_q;
	logic [16:0]        weight_q;
	logic [23:0]        gap_q;
	logic               fb_q;
	logic signed [23:0] pgain_q;

	// filter state
	logic               started_q;
	logic               pos_known_q;
	logic [STAMP_W-1:0] prev_stamp_q;
	logic signed [31:0] prev_pos_q;
	logic signed [31:0] smooth_q;

	// captured item
	logic [STAMP_W-1:0] stamp_q;
	logic               vp_q;
	logic signed [31:0] vv_q;
	logic               pp_q;
	logic signed [31:0] pv_q;

	// datapath registers
	logic signed [32:0] diff_q;
	logic [23:0]        dt_q;
	logic signed [57:0] prod_q;
	logic signed [57:0] acc_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [23:0]        rem_q;
	logic               neg_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] raw_q;
	logic signed [31:0] m_q;
	logic signed [31:0] res_q;

	// output register
	logic               ov_q;
	logic [STAMP_W-1:0] ostamp_q;
	logic signed [31:0] ospeed_q;

	// ---- combinational helpers ----
	logic signed [40:0] dt_full;
	logic               dt_skip;
	logic               use_pos;
	logic [16:0]        w_eff;
	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [57:0] prod_next;
	logic signed [63:0] prod_sh;
	logic signed [31:0] prod_sat;
	logic signed [57:0] prod_mag;
	logic [24:0]        rem_sh;
	logic               rem_ge;
	logic signed [63:0] quot;
	logic signed [63:0] bias_sum;
	logic signed [32:0] m33;
	logic signed [32:0] m_abs;
	logic signed [32:0] lim33;
	logic signed [58:0] lp_sum;
	logic signed [63:0] lp_sh;
	logic               out_free;
	logic               in_acc;

	assign in_acc   = sample.valid && sample.ready;
	assign out_free = !ov_q || result.ready;

	// signed stamp gap; accepted only in (0, gap_limit]
	assign dt_full = $signed({1'b0, stamp_q}) - $signed({1'b0, prev_stamp_q});
	assign dt_skip = dt_full[40] || (dt_full == 41'sd0) || (dt_full[39:0] > {16'b0, gap_q});
	assign use_pos = fb_q && pp_q && pos_known_q;

	// weight above one acts as one
	assign w_eff = (weight_q > ONE_Q16) ? ONE_Q16 : weight_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MULD: begin
				mul_a = diff_q;
				mul_b = POS_SCALE;
			end
			ST_MULP: begin
				mul_a = {raw_q[31], raw_q};
				mul_b = {pgain_q[23], pgain_q};
			end
			ST_MULV: begin
				mul_a = {raw_q[31], raw_q};
				mul_b = {vgain_q[23], vgain_q};
			end
			ST_MULW: begin
				mul_a = {m_q[31], m_q};
				mul_b = $signed({8'b0, w_eff});
			end
			ST_MULS: begin
				mul_a = {smooth_q[31], smooth_q};
				mul_b = $signed({8'b0, 17'(ONE_Q16 - w_eff)});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_next = mul_a * mul_b;

	// floor(prod / 65536), saturated
	assign prod_sh  = {{22{prod_q[57]}}, prod_q[57:16]};
	assign prod_sat = sat32(prod_sh);
	assign prod_mag = prod_q[57] ? -prod_q : prod_q;

	// restoring divide step
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, dt_q};

	// truncating quotient with sign restored
	assign quot = neg_q ? -$signed({11'b0, dvd_q}) : $signed({11'b0, dvd_q});

	assign bias_sum = {{32{prod_sat[31]}}, prod_sat} + {{32{vbias_q[31]}}, vbias_q};

	assign m33   = {m_q[31], m_q};
	assign m_abs = m_q[31] ? -m33 : m33;
	assign lim33 = $signed({2'b0, limit_q});

	assign lp_sum = {acc_q[57], acc_q} + {prod_q[57], prod_q};
	assign lp_sh  = {{21{lp_sum[58]}}, lp_sum[58:16]};

	assign cfg.ready    = 1'b1;
	assign sample.ready = (state_q == ST_IDLE);

	assign result.valid         = ov_q;
	assign result.out_stamp_us  = ostamp_q;
	assign result.forward_speed = ospeed_q;

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vgain_q  <= RST_GAIN;
			vbias_q  <= '0;
			limit_q  <= RST_LIMIT;
			dzone_q  <= RST_DZONE;
			weight_q <= ONE_Q16;
			gap_q    <= RST_GAP;
			fb_q     <= 1'b0;
			pgain_q  <= RST_GAIN;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_VELOCITY_GAIN:    vgain_q  <= cfg.data[23:0];
				REG_VELOCITY_BIAS:    vbias_q  <= cfg.data;
				REG_SPEED_LIMIT:      limit_q  <= cfg.data[30:0];
				REG_DEAD_ZONE:        dzone_q  <= cfg.data[30:0];
				REG_SMOOTHING_WEIGHT: weight_q <= cfg.data[16:0];
				REG_GAP_LIMIT_US:     gap_q    <= cfg.data[23:0];
				REG_FALLBACK_ENABLE:  fb_q     <= cfg.data[0];
				REG_POSITION_GAIN:    pgain_q  <= cfg.data[23:0];
				default: ;
			endcase
		end
	end

	// ---- sequencer and filter state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			started_q    <= 1'b0;
			pos_known_q  <= 1'b0;
			prev_stamp_q <= '0;
			prev_pos_q   <= '0;
			smooth_q     <= '0;
			cnt_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					// every item records its stamp and any position
					prev_stamp_q <= stamp_q;
					if (pp_q) begin
						prev_pos_q  <= pv_q;
						pos_known_q <= 1'b1;
					end
					if (!started_q) begin
						started_q <= 1'b1;
						state_q   <= ST_OUT;
					end else if (dt_skip) begin
						state_q <= ST_IDLE;
					end else if (vp_q) begin
						state_q <= ST_MULV;
					end else if (use_pos) begin
						state_q <= ST_MULD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MULD:  state_q <= ST_DIVI;
				ST_DIVI: begin
					cnt_q   <= DIV_LAST;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0)
						state_q <= ST_DIVF;
				end
				ST_DIVF:  state_q <= ST_MULP;
				ST_MULP:  state_q <= ST_MULPF;
				ST_MULPF: state_q <= ST_MULV;
				ST_MULV:  state_q <= ST_BIAS;
				ST_BIAS:  state_q <= ST_LIMIT;
				ST_LIMIT: state_q <= ST_MULW;
				ST_MULW:  state_q <= ST_MULS;
				ST_MULS:  state_q <= ST_SUM;
				ST_SUM: begin
					smooth_q <= sat32(lp_sh);
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- datapath payload ----
	always_ff @(posedge clk) begin
		prod_q <= prod_next;
		if (in_acc) begin
			stamp_q <= sample.stamp_us;
			vp_q    <= sample.velocity_present;
			vv_q    <= sample.velocity_value;
			pp_q    <= sample.position_present;
			pv_q    <= sample.position_value;
		end
		case (state_q)
			ST_CHECK: begin
				diff_q <= {pv_q[31], pv_q} - {prev_pos_q[31], prev_pos_q};
				dt_q   <= dt_full[23:0];
				raw_q  <= vv_q;
				res_q  <= '0;
			end
			ST_DIVI: begin
				neg_q <= prod_q[57];
				dvd_q <= prod_mag[DVD_W-1:0];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_ge ? 24'(rem_sh - {1'b0, dt_q}) : rem_sh[23:0];
				dvd_q <= {dvd_q[DVD_W-2:0], rem_ge};
			end
			ST_DIVF:  raw_q <= sat32(quot);
			ST_MULPF: raw_q <= prod_sat;
			ST_BIAS:  m_q   <= sat32(bias_sum);
			ST_LIMIT: begin
				if (m_abs < $signed({2'b0, dzone_q}))
					m_q <= '0;
				else if (m33 > lim33)
					m_q <= lim33[31:0];
				else if (m33 < -lim33)
					m_q <= 32'(-lim33);
			end
			ST_MULS:  acc_q <= prod_q;
			ST_SUM:   res_q <= sat32(lp_sh);
			default: ;
		endcase
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			ostamp_q <= stamp_q;
			ospeed_q <= res_q;
		end
	end

endmodule

>>> src/wsc_checker.sv
// Port-level checks on the wheel speed conditioner, attached by bind.
module wsc_checker import wsc_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_valid,
	input logic                      s_ready,
	input logic                      r_valid,
	input logic                      r_ready,
	input logic [STAMP_W-1:0]        r_stamp,
	input logic signed [SPEED_W-1:0] r_speed,
	input logic                      c_ready
);

	// one item at a time: the sample side closes right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("sample accepted while previous item in work");

	// a new result is only produced out of a busy sequencer
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> $past(!s_ready))
		else $error("result appeared without an item in work");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_stamp) && $stable(r_speed))
		else $error("stalled result changed");

	// register writes are never refused
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n) c_ready)
		else $error("configuration port not ready");

endmodule

bind wheel_speed_conditioner wsc_checker u_wsc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_stamp (result.out_stamp_us),
	.r_speed (result.forward_speed),
	.c_ready (cfg.ready)
);
